FILE: sv/mrm_pkg.sv
package mrm_pkg;

	localparam int JOB_ENTRIES = 8;
	localparam int JOB_CNT_W   = 4;
	localparam int RX_CNT_W    = 4;
	localparam int PADDR_W     = 3;

	// register index, taken from paddr[2]
	localparam logic REG_SLAVE_ID = 1'b0;

	localparam logic [1:0] OP_HEADER = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_RESP   = 2'd2;

	localparam logic [1:0] FK_READ   = 2'd0;
	localparam logic [1:0] FK_SINGLE = 2'd1;
	localparam logic [1:0] FK_MULTI  = 2'd2;
	localparam logic [1:0] FK_RSVD   = 2'd3;

	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		EK_DATA,
		EK_CRC_LO,
		EK_CRC_HI,
		EK_VERDICT
	} entry_kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_ID_MISMATCH,
		ST_CRC_ERR,
		ST_CONTENT_MISMATCH,
		ST_BAD_REQ
	} status_t;

	// everything one input item hands to the emitter
	typedef struct packed {
		logic [JOB_CNT_W-1:0]               cnt;
		logic                               restart;
		entry_kind_t [JOB_ENTRIES-1:0]      ekind;
		logic [JOB_ENTRIES-1:0][7:0]        bytes;
		status_t                            status;
		logic [31:0]                        value;
	} job_t;

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] fcode(input logic [1:0] fk);
		logic [7:0] c;
		case (fk)
			FK_READ:   c = FC_READ_HOLDING;
			FK_SINGLE: c = FC_WRITE_SINGLE;
			default:   c = FC_WRITE_MULTI;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/mrm_cfg.sv
module mrm_cfg import mrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [7:0]         slave_id
);

	logic [7:0] slave_id_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SLAVE_ID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= 8'd1;
		end else if (wr_en) begin
			slave_id_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SLAVE_ID) begin
			prdata = {24'h000000, slave_id_q};
		end
	end

	assign slave_id = slave_id_q;

endmodule

FILE: sv/mrm_decode.sv
module mrm_decode import mrm_pkg::*; #(
	parameter int MAX_WRITE_WORDS = 10,
	parameter int RX_FRAME_BYTES  = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  slave_id,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [1:0]  function_kind,
	input  logic [15:0] reg_address,
	input  logic [7:0]  quantity,
	input  logic [15:0] data_word,
	input  logic [7:0]  rx_byte,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	localparam int WR_W  = $clog2(MAX_WRITE_WORDS + 1);
	localparam int RXI_W = $clog2(RX_FRAME_BYTES);
	localparam int VIEW_N = 7;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [1:0]  fk_s1;
	logic [15:0] addr_s1;
	logic [7:0]  qty_s1;
	logic [15:0] word_s1;
	logic [7:0]  rxb_s1;

	logic [1:0]          pf_q, pf_nx;
	logic [15:0]         pa_q, pa_nx;
	logic [7:0]          pq_q, pq_nx;
	logic [WR_W-1:0]     wr_q, wr_nx;
	logic [15:0]         rx_crc_q, rx_crc_nx;
	logic [RX_CNT_W-1:0] rx_cnt_q, rx_cnt_nx;
	logic [15:0]         swv_q, swv_nx;
	logic [7:0]          rx_mem_q [RX_FRAME_BYTES];

	logic        take;
	logic        mem_we;
	logic        bad;
	logic [15:0] crc_b;
	logic [4:0]  cnt_b;
	logic [8:0]  expect_len;
	logic [7:0]  view [VIEW_N];
	logic        hdr_ok;

	assign take     = valid_s1 && ((job.cnt == '0) || job_ready);
	assign in_ready = !valid_s1 || take;
	assign job_valid = valid_s1 && (job.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			fk_s1   <= function_kind;
			addr_s1 <= reg_address;
			qty_s1  <= quantity;
			word_s1 <= data_word;
			rxb_s1  <= rx_byte;
		end
	end

	// response bytes seen so far, with the byte in hand forwarded
	always_comb begin
		for (int i = 0; i < VIEW_N; i++) begin
			view[i] = (rx_cnt_q == RX_CNT_W'(i)) ? rxb_s1 : rx_mem_q[i];
		end
	end

	assign bad = (fk_s1 == FK_RSVD) ||
		((fk_s1 == FK_READ) && ((qty_s1 < 8'd1) || (qty_s1 > 8'd2))) ||
		((fk_s1 == FK_MULTI) && ((qty_s1 < 8'd2) || (qty_s1 > 8'(MAX_WRITE_WORDS))));

	assign crc_b      = crc_step(rx_crc_q, rxb_s1);
	assign cnt_b      = 5'(rx_cnt_q) + 5'd1;
	assign expect_len = (pf_q == FK_READ) ? (9'd5 + {pq_q, 1'b0}) : 9'd8;
	assign hdr_ok     = (view[0] == slave_id) && (view[1] == fcode(pf_q));

	always_comb begin
		job       = '0;
		mem_we    = 1'b0;
		pf_nx     = pf_q;
		pa_nx     = pa_q;
		pq_nx     = pq_q;
		wr_nx     = wr_q;
		rx_crc_nx = rx_crc_q;
		rx_cnt_nx = rx_cnt_q;
		swv_nx    = swv_q;
		case (op_s1)
			OP_HEADER: begin
				if (bad) begin
					job.cnt      = JOB_CNT_W'(1);
					job.ekind[0] = EK_VERDICT;
					job.status   = ST_BAD_REQ;
				end else begin
					job.restart  = 1'b1;
					job.bytes[0] = slave_id;
					job.bytes[1] = fcode(fk_s1);
					job.bytes[2] = addr_s1[15:8];
					job.bytes[3] = addr_s1[7:0];
					pf_nx     = fk_s1;
					pa_nx     = addr_s1;
					pq_nx     = (fk_s1 == FK_SINGLE) ? 8'd1 : qty_s1;
					rx_cnt_nx = '0;
					rx_crc_nx = CRC_INIT;
					case (fk_s1)
						FK_SINGLE: begin
							job.cnt = JOB_CNT_W'(4);
							wr_nx   = WR_W'(1);
						end
						FK_READ: begin
							job.bytes[5] = qty_s1;
							job.ekind[6] = EK_CRC_LO;
							job.ekind[7] = EK_CRC_HI;
							job.cnt      = JOB_CNT_W'(8);
							wr_nx        = '0;
						end
						default: begin
							job.bytes[5] = qty_s1;
							job.bytes[6] = {qty_s1[6:0], 1'b0};
							job.cnt      = JOB_CNT_W'(7);
							wr_nx        = qty_s1[WR_W-1:0];
						end
					endcase
				end
			end
			OP_DATA: begin
				if (wr_q != '0) begin
					job.bytes[0] = word_s1[15:8];
					job.bytes[1] = word_s1[7:0];
					if (pf_q == FK_SINGLE) begin
						swv_nx = word_s1;
					end
					wr_nx = wr_q - WR_W'(1);
					if (wr_q == WR_W'(1)) begin
						job.ekind[2] = EK_CRC_LO;
						job.ekind[3] = EK_CRC_HI;
						job.cnt      = JOB_CNT_W'(4);
					end else begin
						job.cnt = JOB_CNT_W'(2);
					end
				end
			end
			OP_RESP: begin
				mem_we = (5'(rx_cnt_q) < 5'(RX_FRAME_BYTES));
				if ({4'b0000, cnt_b} >= expect_len) begin
					job.cnt      = JOB_CNT_W'(1);
					job.ekind[0] = EK_VERDICT;
					rx_cnt_nx    = '0;
					rx_crc_nx    = CRC_INIT;
					if (!hdr_ok) begin
						job.status = ST_ID_MISMATCH;
					end else if (crc_b != 16'h0000) begin
						job.status = ST_CRC_ERR;
					end else if (pf_q == FK_READ) begin
						if (((pq_q == 8'd1) || (pq_q == 8'd2)) &&
						    (view[2] == {pq_q[6:0], 1'b0})) begin
							job.status = ST_OK;
							job.value  = (pq_q == 8'd1) ? {16'h0000, view[3], view[4]} :
							             {view[5], view[6], view[3], view[4]};
						end else begin
							job.status = ST_CONTENT_MISMATCH;
						end
					end else if (pf_q == FK_SINGLE) begin
						job.status = ({view[2], view[3], view[4], view[5]} == {pa_q, swv_q}) ?
						             ST_OK : ST_CONTENT_MISMATCH;
					end else begin
						job.status = ({view[2], view[3], view[4], view[5]} ==
						              {pa_q, 8'h00, pq_q}) ? ST_OK : ST_CONTENT_MISMATCH;
					end
				end else begin
					rx_cnt_nx = cnt_b[RX_CNT_W-1:0];
					rx_crc_nx = crc_b;
				end
			end
			default: begin
				job = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_q     <= FK_READ;
			pa_q     <= '0;
			pq_q     <= '0;
			wr_q     <= '0;
			rx_crc_q <= CRC_INIT;
			rx_cnt_q <= '0;
			swv_q    <= '0;
		end else if (take) begin
			pf_q     <= pf_nx;
			pa_q     <= pa_nx;
			pq_q     <= pq_nx;
			wr_q     <= wr_nx;
			rx_crc_q <= rx_crc_nx;
			rx_cnt_q <= rx_cnt_nx;
			swv_q    <= swv_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take && mem_we) begin
			rx_mem_q[rx_cnt_q[RXI_W-1:0]] <= rxb_s1;
		end
	end

	a_rx_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_cnt_q <= RX_CNT_W'(8))
		else $error("response count ran past the longest frame");

	a_pf_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pf_q != FK_RSVD)
		else $error("reserved function latched as pending");

	a_read_qty: assert property (@(posedge clk) disable iff (!arst_n)
		(pf_q == FK_READ) |-> (pq_q <= 8'd2))
		else $error("pending read quantity out of range");

	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		take && (op_s1 == OP_DATA) && (wr_q == '0) |-> (job.cnt == '0))
		else $error("unexpected data word produced bytes");

endmodule

FILE: sv/mrm_emit.sv
module mrm_emit import mrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  job_t               job,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic [7:0]         tx_byte,
	output logic               frame_last,
	output logic [2:0]         status,
	output logic signed [31:0] read_value
);

	job_t                 job_q;
	logic [JOB_CNT_W-1:0] idx_q;
	logic [15:0]          tx_crc_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  tx_byte_q;
	logic        frame_last_q;
	status_t     status_q;
	logic [31:0] read_value_q;

	logic        busy;
	logic        slot_free;
	logic        emit;
	logic        last_emit;
	logic        load;
	entry_kind_t ek;
	logic [15:0] base;
	logic [15:0] crc_nx;
	logic        e_kind;
	logic [7:0]  e_byte;
	logic        e_last;
	status_t     e_status;
	logic [31:0] e_value;

	assign busy      = idx_q != job_q.cnt;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = busy && slot_free;
	assign last_emit = emit && (idx_q == (job_q.cnt - JOB_CNT_W'(1)));
	assign job_ready = !busy || last_emit;
	assign load      = job_valid && job_ready;

	assign ek   = job_q.ekind[idx_q[2:0]];
	// a new request frame starts its CRC over
	assign base = ((idx_q == '0) && job_q.restart) ? CRC_INIT : tx_crc_q;

	always_comb begin
		e_kind   = 1'b0;
		e_byte   = '0;
		e_last   = 1'b0;
		e_status = ST_OK;
		e_value  = '0;
		crc_nx   = base;
		case (ek)
			EK_DATA: begin
				e_byte = job_q.bytes[idx_q[2:0]];
				crc_nx = crc_step(base, job_q.bytes[idx_q[2:0]]);
			end
			EK_CRC_LO: begin
				e_byte = base[7:0];
			end
			EK_CRC_HI: begin
				e_byte = base[15:8];
				e_last = 1'b1;
				crc_nx = CRC_INIT;
			end
			default: begin
				e_kind   = 1'b1;
				e_status = job_q.status;
				e_value  = job_q.value;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q       <= '0;
			idx_q       <= '0;
			tx_crc_q    <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				tx_crc_q <= crc_nx;
			end
			if (load) begin
				job_q <= job;
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + JOB_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q       <= e_kind;
			tx_byte_q    <= e_byte;
			frame_last_q <= e_last;
			status_q     <= e_status;
			read_value_q <= e_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign tx_byte    = tx_byte_q;
	assign frame_last = frame_last_q;
	assign status     = status_q;
	assign read_value = read_value_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= job_q.cnt)
		else $error("emit index past job length");

	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (ek == EK_CRC_HI) |=> (tx_crc_q == CRC_INIT))
		else $error("tx CRC not reinitialized after frame end");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q |-> (tx_byte_q == 8'h00) && !frame_last_q)
		else $error("verdict carries transmit fields");

endmodule

FILE: sv/modbus_rtu_master_framer.sv
// Flow: an accepted item is registered in decode, then buffered as a job in the emitter,
// whose results are registered at the output; an earlier job still draining delays it.
// The emitter walks a buffered job one result per cycle unless out_ready stalls it,
// running the tx CRC. An item has 1 to 8 results; one with none skips the emitter.
// Reset (arst_n low, asynchronous): pipeline empty, slave_id 1, CRCs 0xFFFF,
// no request pending; response byte store is not cleared.
module modbus_rtu_master_framer import mrm_pkg::*; #(
	parameter int MAX_WRITE_WORDS = 10,
	parameter int RX_FRAME_BYTES  = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [1:0]         function_kind,
	input  logic [15:0]        reg_address,
	input  logic [7:0]         quantity,
	input  logic [15:0]        data_word,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic [7:0]         tx_byte,
	output logic               frame_last,
	output logic [2:0]         status,
	output logic signed [31:0] read_value
);

	logic [7:0] slave_id;
	logic       job_valid;
	logic       job_ready;
	job_t       job;

	mrm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.slave_id (slave_id)
	);

	mrm_decode #(
		.MAX_WRITE_WORDS (MAX_WRITE_WORDS),
		.RX_FRAME_BYTES  (RX_FRAME_BYTES)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_id      (slave_id),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.function_kind (function_kind),
		.reg_address   (reg_address),
		.quantity      (quantity),
		.data_word     (data_word),
		.rx_byte       (rx_byte),
		.job_valid     (job_valid),
		.job_ready     (job_ready),
		.job           (job)
	);

	mrm_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.frame_last (frame_last),
		.status     (status),
		.read_value (read_value)
	);

endmodule
